FILE: rtl/core/esma_pkg.sv
// shared types and constants for the encoder speed moving average block
// no dependencies; imported by encoder_speed_moving_average
package esma_pkg;

  localparam int WORD_W = 16;

  typedef logic [WORD_W-1:0]        word_t;
  typedef logic signed [WORD_W-1:0] speed_t;
  typedef logic [2*WORD_W-1:0]      tdata_t;

  localparam word_t COUNTS_PER_REV_RST = 16'd4096;

endpackage

FILE: rtl/core/encoder_speed_moving_average.sv
// encoder speed with a moving average over a ring of recent speeds
// depends on esma_pkg (types, register reset value)
//
// a request moves through the stage registers into the output register
// throughput: one request per cycle unless the output stalls; the ring memory is
//   read at accept and written in stage 1; a running sum replaces the ring sweep
// reset (rst_n low, synchronous): ring valid bits, running sum, index,
//   first-tick flag and counts_per_rev (4096) clear at once; no clearing pass
module encoder_speed_moving_average #(
  parameter int AVG_DEPTH = 8  // ring length, 2 to 64
) (
  input  logic            clk,
  input  logic            rst_n,
  // configuration: counts_per_rev
  input  logic            cfg_we,
  input  esma_pkg::word_t cfg_wdata,
  // input requests
  input  logic            in_tvalid,
  output logic            in_tready,
  input  esma_pkg::tdata_t in_tdata,   // [15:0] counter_value, [31:16] overflow_count
  input  logic            in_tuser,    // [0] count_down
  // results
  output logic            out_tvalid,
  input  logic            out_tready,
  output esma_pkg::tdata_t out_tdata   // [15:0] instant_speed, [31:16] average_speed
);
  import esma_pkg::*;

  // ring index and running sum widths
  localparam int IDX_W = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
  localparam int SUM_W = WORD_W + IDX_W;
  localparam int MAG_W = SUM_W;
  // exact division of the sum magnitude by AVG_DEPTH: multiply by a rounded-up
  // reciprocal of MAG_W+1 bits, then shift right by MAG_W+IDX_W
  localparam int RCP_W  = MAG_W + 1;
  localparam int SHF    = MAG_W + IDX_W;
  localparam int PROD_W = MAG_W + RCP_W;
  localparam logic [63:0] RECIP_L =
    ((64'd1 << SHF) + 64'(AVG_DEPTH) - 64'd1) / 64'(AVG_DEPTH);
  localparam logic [RCP_W-1:0] RECIP = RECIP_L[RCP_W-1:0];
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(AVG_DEPTH - 1);

  // configuration register
  word_t cpr_r;

  // per-tick state
  logic  first_r;
  word_t prev_r;
  logic [IDX_W-1:0] idx_r;
  logic [IDX_W-1:0] idx_nxt;
  logic signed [SUM_W-1:0] sum_r;
  logic signed [SUM_W-1:0] sum_nxt;

  // ring memory, its per-entry valid bits and registered read data
  word_t ring_mem [AVG_DEPTH];
  logic [AVG_DEPTH-1:0] vld_r;
  word_t rd_q_r;
  logic  rd_vld_r;

  // stage 1: counter delta and overflow term
  logic  s1_v_r;
  word_t s1_diff_r;
  word_t s1_term_r;
  logic  s1_down_r;
  logic  s1_first_r;
  logic [IDX_W-1:0] s1_idx_r;
  logic [2*WORD_W-1:0] term_full;
  word_t speed_nxt;
  word_t old_speed;

  // stage 2: instant speed; the running sum already holds this request
  logic  s2_v_r;
  word_t s2_speed_r;

  // stage 3: sum magnitude and sign
  logic  s3_v_r;
  word_t s3_speed_r;
  logic [MAG_W-1:0] s3_mag_r;
  logic  s3_neg_r;
  logic [MAG_W-1:0] mag_nxt;

  // stage 4: reciprocal product
  logic  s4_v_r;
  word_t s4_speed_r;
  logic [PROD_W-1:0] s4_prod_r;
  logic  s4_neg_r;
  word_t quot;
  word_t avg_nxt;

  // output register
  logic  out_v_r;
  word_t out_speed_r;
  word_t out_avg_r;

  logic en;
  logic in_acc;
  logic ring_we;

  // whole pipeline advances together whenever the output register can load
  assign en        = !out_v_r || out_tready;
  assign in_tready = en;
  assign in_acc    = in_tvalid && en;
  assign ring_we   = s1_v_r && en;

  assign out_tvalid = out_v_r;
  assign out_tdata  = {out_avg_r, out_speed_r};

  // counts_per_rev register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cpr_r <= COUNTS_PER_REV_RST;
    end else if (cfg_we) begin
      cpr_r <= cfg_wdata;
    end
  end

  assign term_full = in_tdata[2*WORD_W-1:WORD_W] * cpr_r;
  assign idx_nxt   = (idx_r == IDX_LAST) ? '0 : idx_r + 1'b1;

  // accept side: first-tick flag, previous count, ring index
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_r <= 1'b1;
      prev_r  <= '0;
      idx_r   <= '0;
    end else if (in_acc) begin
      first_r <= 1'b0;
      prev_r  <= in_tdata[WORD_W-1:0];
      idx_r   <= idx_nxt;
    end
  end

  // stage 1 payload, captured at accept
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_diff_r  <= in_tdata[WORD_W-1:0] - prev_r;
      s1_term_r  <= term_full[WORD_W-1:0];
      s1_down_r  <= in_tuser;
      s1_first_r <= first_r;
      s1_idx_r   <= idx_r;
    end
  end

  // ring read at accept; the entry written by the request in stage 1 has a
  // different index, and the next request on that index is read only after
  // the write has landed
  always_ff @(posedge clk) begin
    if (in_acc) begin
      rd_q_r <= ring_mem[idx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (ring_we) begin
      ring_mem[s1_idx_r] <= speed_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (in_acc) begin
        rd_vld_r <= vld_r[idx_r];
      end
      if (ring_we) begin
        vld_r[s1_idx_r] <= 1'b1;
      end
    end
  end

  // instant speed, modulo 2^16; a never-written entry reads as zero
  always_comb begin
    if (s1_first_r) begin
      speed_nxt = '0;
    end else if (s1_down_r) begin
      speed_nxt = s1_diff_r - s1_term_r;
    end else begin
      speed_nxt = s1_diff_r + s1_term_r;
    end
    old_speed = rd_vld_r ? rd_q_r : '0;
    sum_nxt   = sum_r - {{(SUM_W-WORD_W){old_speed[WORD_W-1]}}, old_speed}
                      + {{(SUM_W-WORD_W){speed_nxt[WORD_W-1]}}, speed_nxt};
  end

  // running sum over the ring
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
    end else if (ring_we) begin
      sum_r <= sum_nxt;
    end
  end

  // magnitude of the sum; the most negative sum maps to its unsigned value
  assign mag_nxt = sum_r[SUM_W-1] ? MAG_W'(-sum_r) : MAG_W'(sum_r);

  // truncation toward zero: divide the magnitude, then restore the sign
  assign quot    = s4_prod_r[SHF +: WORD_W];
  assign avg_nxt = s4_neg_r ? -quot : quot;

  // stage valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      s3_v_r  <= 1'b0;
      s4_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r  <= in_tvalid;
      s2_v_r  <= s1_v_r;
      s3_v_r  <= s2_v_r;
      s4_v_r  <= s3_v_r;
      out_v_r <= s4_v_r;
    end
  end

  // stage payloads
  always_ff @(posedge clk) begin
    if (en) begin
      s2_speed_r  <= speed_nxt;
      s3_speed_r  <= s2_speed_r;
      s3_mag_r    <= mag_nxt;
      s3_neg_r    <= sum_r[SUM_W-1];
      s4_speed_r  <= s3_speed_r;
      s4_prod_r   <= PROD_W'(s3_mag_r) * PROD_W'(RECIP);
      s4_neg_r    <= s3_neg_r;
      out_speed_r <= s4_speed_r;
      out_avg_r   <= avg_nxt;
    end
  end

  // running sum never leaves the range of AVG_DEPTH signed 16-bit speeds
  a_sum_range: assert property (@(posedge clk) disable iff (!rst_n)
    (int'(sum_r) >= -32768 * AVG_DEPTH) &&
    (int'(sum_r) <= 32767 * AVG_DEPTH))
    else $error("running sum out of range");

  // ring index stays inside the ring
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r <= IDX_LAST)
    else $error("ring index out of range");

  // valid bits are only ever set until the next reset
  a_vld_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && ((vld_r & $past(vld_r)) != $past(vld_r))) == 1'b0)
    else $error("ring valid bit cleared");

  // first-tick flag drops only with an accepted request
  a_first_fall: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(first_r) |-> $past(in_tvalid && in_tready))
    else $error("first-tick flag dropped without a request");

  // a stall freezes every stage
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable({s1_v_r, s2_v_r, s3_v_r, s4_v_r, sum_r, idx_r}))
    else $error("pipeline moved during a stall");

endmodule
